/* sv/half_cosine_response_convolver_unit_assert.svh */
// Assertion macros for the half-cosine response convolver
`ifndef HALF_COSINE_RESPONSE_CONVOLVER_UNIT_ASSERT_SVH
`define HALF_COSINE_RESPONSE_CONVOLVER_UNIT_ASSERT_SVH
`define HCRC_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define HCRC_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

/* sv/hcrc_pkg.sv */
// Package: shared types and constants of the half-cosine response convolver
`timescale 1ns / 1ps
package hcrc_pkg;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 22;

	typedef enum logic [CfgIdxW-1:0] {
		REG_AMPLITUDE = 3'd0,
		REG_DIP       = 3'd1,
		REG_UNDER     = 3'd2,
		REG_FALL      = 3'd3,
		REG_RISE      = 3'd4,
		REG_DROP      = 3'd5,
		REG_RETURN    = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SHAPE1,
		ST_SHAPE2,
		ST_SHAPE3,
		ST_WRITE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_OUT
	} state_t;

	// table of (1 - cos(pi*k/16)) / 2 in unsigned Q1.16
	function automatic logic [16:0] wtab(input logic [4:0] k);
		logic [16:0] v;
		begin
			case (k)
				5'd0: v = 17'd0;
				5'd1: v = 17'd630;
				5'd2: v = 17'd2494;
				5'd3: v = 17'd5522;
				5'd4: v = 17'd9598;
				5'd5: v = 17'd14563;
				5'd6: v = 17'd20228;
				5'd7: v = 17'd26375;
				5'd8: v = 17'd32768;
				5'd9: v = 17'd39161;
				5'd10: v = 17'd45308;
				5'd11: v = 17'd50973;
				5'd12: v = 17'd55938;
				5'd13: v = 17'd60014;
				5'd14: v = 17'd63042;
				5'd15: v = 17'd64906;
				default: v = 17'd65536;
			endcase
			return v;
		end
	endfunction
endpackage

/* sv/hcrc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read
`timescale 1ns / 1ps
module hcrc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/hcrc_divider.sv */
// Restoring divider: quotient = floor(num * 65536 / den), num < den
`timescale 1ns / 1ps
module hcrc_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [14:0] num,
	input  logic [14:0] den,
	output logic        busy,
	output logic [15:0] quot
);
	logic [15:0] rem_q;
	logic [14:0] den_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;

	assign trial = {rem_q, 1'b0} - {2'b0, den_q};
	assign busy = (cnt_q != 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quot  <= '0;
		end else if (busy) begin
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				quot  <= {quot[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[14:0], 1'b0};
				quot  <= {quot[14:0], 1'b0};
			end
		end
	end
endmodule

/* sv/half_cosine_response_convolver_unit.sv */
// Top level: half-cosine response evaluation and causal convolution
// Sequence from transfer in to result valid for sample n of a series: phase divide,
//   shape, one MAC per stored entry, drain, round; the divide is skipped when the
//   segment needs none, and all but the output step when the store is full.
// Throughput: one item at a time; the next input transfer waits for the result transfer.
// Reset: registers to defaults, sample count to zero; the stores are not cleared.
`timescale 1ns / 1ps
module half_cosine_response_convolver_unit import hcrc_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [39:0]         s_tdata,  // sample_time[23:0], stimulus[39:24]
	input  logic                s_tuser,  // first
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata,  // model_value[31:0]
	output logic                m_tuser,  // overflow
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data
);
	localparam int unsigned AW = $clog2(MAX_SAMPLES);
	localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);

	logic signed [21:0] amp_q;
	logic [16:0] c1_q;
	logic [18:0] c2_q;
	logic [10:0] m1_q;
	logic [12:0] m2_q, m3_q, m4_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= 22'sd4096;
			c1_q  <= 17'd16384;
			c2_q  <= 19'd32768;
			m1_q  <= 11'd256;
			m2_q  <= 13'd768;
			m3_q  <= 13'd1024;
			m4_q  <= 13'd1024;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_AMPLITUDE: amp_q <= cfg_data;
				REG_DIP:       c1_q  <= cfg_data[16:0];
				REG_UNDER:     c2_q  <= cfg_data[18:0];
				REG_FALL:      m1_q  <= cfg_data[10:0];
				REG_RISE:      m2_q  <= cfg_data[12:0];
				REG_DROP:      m3_q  <= cfg_data[12:0];
				REG_RETURN:    m4_q  <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic [NW-1:0] n_q;
	logic [AW-1:0] k_q;
	logic signed [15:0] stim_q;
	logic [14:0] d_q, mseg_q;
	logic signed [19:0] sv_q, ev_q;
	logic zero_q, full_q, mac_v_q;
	logic [16:0] w_q;
	logic signed [37:0] dv_q;
	logic signed [31:0] resp_q;
	logic signed [63:0] acc_q;
	logic signed [47:0] prod_q;
	logic prod_v_q;
	logic [31:0] y_q;
	logic ovf_q;

	logic div_busy, div_start;
	logic [15:0] div_quot;

	logic in_acc;
	logic in_acc_d_q;
	// the FSM is still idle in the cycle after a transfer; hold off until it leaves idle
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid && !in_acc_d_q;
	assign in_acc = s_tvalid && s_tready;

	// segment boundaries
	logic signed [24:0] t2, t3, t4, t5;
	assign t2 = 25'(m1_q);
	assign t3 = t2 + 25'(m2_q);
	assign t4 = t3 + 25'(m3_q);
	assign t5 = t4 + 25'(m4_q);

	hcrc_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(d_q), .den(mseg_q), .busy(div_busy), .quot(div_quot)
	);

	// shape step: w from table interpolation
	logic [4:0] wi;
	logic [11:0] wf;
	logic signed [17:0] wdiff;
	logic signed [30:0] wmul;
	assign wi = {1'b0, div_quot[15:12]};
	assign wf = div_quot[11:0];
	assign wdiff = 18'(signed'({1'b0, wtab(wi + 5'd1)})) - 18'(signed'({1'b0, wtab(wi)}));
	assign wmul = wdiff * signed'({1'b0, wf}) + 31'sd2048;

	logic signed [20:0] esd;
	assign esd = 21'(ev_q) - 21'(sv_q);

	logic signed [20:0] vval;
	assign vval = 21'(sv_q) + 21'((dv_q + 38'sd32768) >>> 16);
	logic signed [42:0] av;
	assign av = amp_q * vval;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0] h_rd;
	logic [31:0] r_rd;
	assign wr_en = (state_q == ST_WRITE);
	assign wr_addr = n_q[AW-1:0];

	hcrc_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_hist (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(stim_q),
		.raddr(k_q), .rdata(h_rd)
	);
	hcrc_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_resp (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(resp_q),
		.raddr(AW'(n_q[AW-1:0] - k_q)), .rdata(r_rd)
	);

	assign div_start = (state_q == ST_IDLE) && in_acc_d_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc_d_q) state_d = full_q ? ST_OUT : (zero_q ? ST_SHAPE1 : ST_DIV);
			ST_DIV: if (!div_busy) state_d = ST_SHAPE1;
			ST_SHAPE1: state_d = ST_SHAPE2;
			ST_SHAPE2: state_d = ST_SHAPE3;
			ST_SHAPE3: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_MAC;
			ST_MAC: if (k_q == n_q[AW-1:0]) state_d = ST_DRAIN;
			ST_DRAIN: if (!mac_v_q && !prod_v_q) state_d = ST_ROUND;
			ST_ROUND: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			m_tvalid <= 1'b0;
			in_acc_d_q <= 1'b0;
			mac_v_q <= 1'b0;
			prod_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			in_acc_d_q <= in_acc;
			mac_v_q <= (state_q == ST_MAC);
			prod_v_q <= mac_v_q;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (state_q == ST_OUT) m_tvalid <= 1'b1;
			if (in_acc && s_tuser) n_q <= '0;
			if (state_q == ST_ROUND) n_q <= n_q + NW'(1);
		end
	end

	logic signed [24:0] tt;
	assign tt = 25'(signed'(s_tdata[23:0]));

	always_ff @(posedge clk) begin
		if (in_acc) begin
			stim_q <= s_tdata[39:24];
			full_q <= !s_tuser && (n_q >= NW'(MAX_SAMPLES));
			if (tt < 0 || tt > t5) begin
				sv_q <= '0; ev_q <= '0; d_q <= '0; mseg_q <= '0; zero_q <= 1'b1;
			end else if (tt < t2) begin
				sv_q <= '0; ev_q <= -20'(c1_q);
				d_q <= 15'(tt); mseg_q <= 15'(m1_q);
				zero_q <= (tt >= 25'(m1_q));
			end else if (tt < t3) begin
				sv_q <= -20'(c1_q); ev_q <= 20'sd65536;
				d_q <= 15'(tt - t2); mseg_q <= 15'(m2_q);
				zero_q <= ((tt - t2) >= 25'(m2_q));
			end else if (tt < t4) begin
				sv_q <= 20'sd65536; ev_q <= -20'(c2_q);
				d_q <= 15'(tt - t3); mseg_q <= 15'(m3_q);
				zero_q <= ((tt - t3) >= 25'(m3_q));
			end else begin
				sv_q <= -20'(c2_q); ev_q <= '0;
				d_q <= 15'(tt - t4); mseg_q <= 15'(m4_q);
				zero_q <= ((tt - t4) >= 25'(m4_q));
			end
		end
		if (state_q == ST_SHAPE1)
			w_q <= zero_q ? 17'd65536 : 17'(wtab(wi) + 17'(wmul >>> 12));
		if (state_q == ST_SHAPE2) dv_q <= esd * signed'({1'b0, w_q});
		if (state_q == ST_SHAPE3) resp_q <= 32'((av + 43'sd2048) >>> 12);
		if (state_q == ST_WRITE) begin
			k_q <= '0;
			acc_q <= '0;
		end else if (state_q == ST_MAC && k_q != n_q[AW-1:0]) begin
			k_q <= k_q + AW'(1);
		end
		if (mac_v_q) prod_q <= signed'(h_rd) * signed'(r_rd);
		if (prod_v_q) acc_q <= acc_q + 64'(prod_q);
		if (state_q == ST_ROUND) begin
			if (full_q) begin
				y_q <= '0; ovf_q <= 1'b1;
			end else begin
				ovf_q <= 1'b0;
				if (((acc_q + 64'sd128) >>> 8) > 64'sd2147483647) y_q <= 32'h7fffffff;
				else if (((acc_q + 64'sd128) >>> 8) < -64'sd2147483648) y_q <= 32'h80000000;
				else y_q <= 32'((acc_q + 64'sd128) >>> 8);
			end
		end
		if (state_q == ST_OUT && full_q) begin
			y_q <= '0; ovf_q <= 1'b1;
		end
	end

	assign m_tdata = y_q;
	assign m_tuser = ovf_q;
endmodule

/* sv/hcrc_checker.sv */
// Port-level checker for the convolver and its bind
`timescale 1ns / 1ps
`include "half_cosine_response_convolver_unit_assert.svh"
module hcrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	`HCRC_ASSERT_IMP(ovf_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 32'd0)
	`HCRC_ASSERT_IMP(no_in_while_out, clk, arst_n, m_tvalid, !s_tready)
	`HCRC_ASSERT_NXT(out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`HCRC_ASSERT_NXT(busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready)
endmodule

bind half_cosine_response_convolver_unit hcrc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
